@@ rtl/bsed_pkg.sv @@
// shared types and constants of the backslash escape decoder
package bsed_pkg;

	// most results one input item can cause
	localparam int unsigned RES_MAX = 4;
	localparam int unsigned RES_IDX_W = $clog2(RES_MAX);
	localparam int unsigned RES_CNT_W = $clog2(RES_MAX + 1);

	typedef logic [RES_MAX-1:0][7:0] res_bytes_t;

	// all results of one item, handed from the front to the back
	typedef struct packed {
		res_bytes_t           bytes;     // result bytes, entry 0 first
		logic [RES_IDX_W-1:0] last_idx;  // index of the last result
		logic                 no_byte;   // single result without a byte
		logic                 done;      // last result ends the line's output
		logic                 stopped;   // last result ends output by stop escape
	} bundle_t;

	// front to queue
	typedef struct packed {
		logic    push;
		bundle_t data;
	} push_t;

	// queue head as seen by the back
	typedef struct packed {
		logic    valid;
		bundle_t data;
	} head_t;

endpackage

@@ rtl/bsed_in_if.sv @@
// input channel: one text byte with word and line end marks
interface bsed_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       byte_present;
	logic       word_end;
	logic       line_end;

	modport source (
		output valid, text_byte, byte_present, word_end, line_end,
		input  ready
	);
	modport sink (
		input  valid, text_byte, byte_present, word_end, line_end,
		output ready
	);
endinterface

@@ rtl/bsed_out_if.sv @@
// output channel: one decoded result
interface bsed_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       run_last;
	logic       output_done;
	logic       stopped;

	modport source (
		output valid, out_byte, byte_valid, run_last, output_done, stopped,
		input  ready
	);
	modport sink (
		input  valid, out_byte, byte_valid, run_last, output_done, stopped,
		output ready
	);
endinterface

@@ rtl/backslash_escape_decoder.sv @@
// top level of the backslash escape decoder: config registers, front, queue and back
//
// Takes echo text one byte per transaction on in_item, with word and line end
// marks, and sends the output text one byte per transaction on out_item. Words
// are joined by a space, a newline closes the line when newline_enable is set,
// and with escape_enable set the usual backslash escapes (\\ \a \b \e \f \n \r
// \t \v, \0 octal, \x hex) are decoded; \c ends the line's output with a
// result that has byte_valid 0 and stopped 1, and bytes are then dropped up to
// the line end. The front accepts one input transaction per cycle while the
// queue has room and turns it into a bundle of zero to four results in that
// same cycle; bundles wait in a queue of QUEUE_DEPTH entries, and the back
// sends one result per cycle through a registered output while the receiver
// is ready. An item with k results thus takes k output transactions, and the
// input keeps flowing at one item per cycle as long as the queue has room, so
// ordinary text (one result per byte) runs at one byte per cycle end to end,
// passing a queue entry and the output register. The last result of each
// item carries run_last. Registers: escape_enable at byte address 0,
// newline_enable at byte address 4; write them only while the block is idle.
module backslash_escape_decoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	bsed_in_if.sink     in_item,
	bsed_out_if.source  out_item,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bsed_pkg::*;

	logic    escape_enable_q;
	logic    newline_enable_q;
	logic    cfg_wr;
	logic    queue_ready;
	logic    pop;
	push_t   push;
	head_t   head;

	// apb: always ready, word address picks the register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = {31'd0, paddr[2] ? newline_enable_q : escape_enable_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_enable_q  <= 1'b0;
			newline_enable_q <= 1'b1;
		end else if (cfg_wr) begin
			if (paddr[2])
				newline_enable_q <= pwdata[0];
			else
				escape_enable_q <= pwdata[0];
		end
	end

	// front: decode state lives here, one item per cycle while the queue has room
	bsed_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_item        (in_item),
		.escape_enable  (escape_enable_q),
		.newline_enable (newline_enable_q),
		.queue_ready    (queue_ready),
		.push           (push)
	);

	// bundles of results waiting for the output
	bsed_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.ready  (queue_ready),
		.head   (head),
		.pop    (pop)
	);

	// back: serializes each bundle onto the output channel
	bsed_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.out_item (out_item)
	);

endmodule

@@ rtl/bsed_front.sv @@
// front: accepts items, runs the escape decoder and builds result bundles
module bsed_front (
	input  logic             clk,
	input  logic             arst_n,
	bsed_in_if.sink          in_item,
	input  logic             escape_enable,
	input  logic             newline_enable,
	input  logic             queue_ready,
	output bsed_pkg::push_t  push
);
	import bsed_pkg::*;

	typedef enum logic [5:0] {
		MODE_IDLE = 6'b000001,
		MODE_BSL  = 6'b000010,
		MODE_OCT  = 6'b000100,
		MODE_HEX0 = 6'b001000,
		MODE_HEX1 = 6'b010000,
		MODE_DROP = 6'b100000
	} mode_t;

	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_BEL   = 8'h07;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LC    = 8'h63;
	localparam logic [7:0] CH_LE    = 8'h65;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LN    = 8'h6E;
	localparam logic [7:0] CH_LR    = 8'h72;
	localparam logic [7:0] CH_LT    = 8'h74;
	localparam logic [7:0] CH_LV    = 8'h76;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;

	// {valid, value} of a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c inside {[CH_ZERO:CH_NINE]})
			r = {1'b1, c[3:0]};
		else if (c inside {[CH_LA:CH_LF]} || c inside {[CH_UA:CH_UF]})
			r = {1'b1, c[3:0] + 4'd9};
		return r;
	endfunction

	// appends one result byte, dropping any beyond the bundle size
	function automatic void emit(inout res_bytes_t r, inout logic [RES_CNT_W-1:0] n,
			input logic [7:0] b);
		if (n < RES_CNT_W'(RES_MAX)) begin
			r[n[RES_IDX_W-1:0]] = b;
			n = n + RES_CNT_W'(1);
		end
	endfunction

	mode_t      mode_q, mode_d;
	logic [7:0] esc_val_q, esc_val_d;
	logic [1:0] dig_cnt_q, dig_cnt_d;
	logic       space_q, space_d;

	res_bytes_t           res;
	logic [RES_CNT_W-1:0] res_n;
	logic                 stop;
	logic                 fall;
	logic                 no_byte;
	logic [4:0]           hx;
	logic [1:0]           dig_inc;

	logic       accept;
	logic [7:0] b;
	logic       present, line, word;

	assign in_item.ready = queue_ready;
	assign accept  = in_item.valid && queue_ready;
	assign b       = in_item.text_byte;
	assign present = in_item.byte_present;
	assign line    = in_item.line_end;
	assign word    = in_item.line_end || in_item.word_end;

	always_comb begin
		mode_d    = mode_q;
		esc_val_d = esc_val_q;
		dig_cnt_d = dig_cnt_q;
		space_d   = space_q;
		res       = '0;
		res_n     = '0;
		stop      = 1'b0;
		fall      = 1'b0;
		no_byte   = 1'b0;
		hx        = hex_digit(b);
		dig_inc   = dig_cnt_q + 2'd1;

		if (mode_q == MODE_DROP) begin
			// swallow everything up to the line end
			if (line) begin
				mode_d  = MODE_IDLE;
				space_d = 1'b0;
			end
		end else if (present || word) begin
			if (space_q) begin
				emit(res, res_n, CH_SPACE);
				space_d = 1'b0;
			end
			if (present) begin
				case (mode_q)
					MODE_BSL: begin
						mode_d = MODE_IDLE;
						case (b)
							CH_BSL: emit(res, res_n, CH_BSL);
							CH_LA:  emit(res, res_n, CH_BEL);
							CH_LB:  emit(res, res_n, CH_BS);
							CH_LC:  stop = 1'b1;
							CH_LE:  emit(res, res_n, CH_ESC);
							CH_LF:  emit(res, res_n, CH_FF);
							CH_LN:  emit(res, res_n, CH_NL);
							CH_LR:  emit(res, res_n, CH_CR);
							CH_LT:  emit(res, res_n, CH_TAB);
							CH_LV:  emit(res, res_n, CH_VT);
							CH_ZERO: begin
								mode_d    = MODE_OCT;
								esc_val_d = 8'd0;
								dig_cnt_d = 2'd0;
							end
							CH_LX: mode_d = MODE_HEX0;
							default: begin
								emit(res, res_n, CH_BSL);
								emit(res, res_n, b);
							end
						endcase
					end
					MODE_OCT: begin
						if (b inside {[CH_ZERO:CH_SEVEN]}) begin
							esc_val_d = {esc_val_q[4:0], b[2:0]};
							dig_cnt_d = dig_inc;
							if (dig_inc == 2'd3) begin
								emit(res, res_n, esc_val_d);
								mode_d    = MODE_IDLE;
								dig_cnt_d = 2'd0;
							end
						end else begin
							emit(res, res_n, esc_val_q);
							mode_d    = MODE_IDLE;
							dig_cnt_d = 2'd0;
							fall      = 1'b1;
						end
					end
					MODE_HEX0: begin
						if (hx[4]) begin
							esc_val_d = {4'd0, hx[3:0]};
							mode_d    = MODE_HEX1;
						end else begin
							emit(res, res_n, CH_BSL);
							emit(res, res_n, CH_LX);
							mode_d = MODE_IDLE;
							fall   = 1'b1;
						end
					end
					MODE_HEX1: begin
						mode_d = MODE_IDLE;
						if (hx[4]) begin
							emit(res, res_n, {esc_val_q[3:0], hx[3:0]});
						end else begin
							emit(res, res_n, esc_val_q);
							fall = 1'b1;
						end
					end
					default: begin
						mode_d = MODE_IDLE;
						fall   = 1'b1;
					end
				endcase
				// byte taken as plain text
				if (fall) begin
					if (escape_enable && b == CH_BSL)
						mode_d = MODE_BSL;
					else
						emit(res, res_n, b);
				end
			end

			if (stop) begin
				res       = '0;
				res_n     = RES_CNT_W'(1);
				no_byte   = 1'b1;
				mode_d    = line ? MODE_IDLE : MODE_DROP;
				esc_val_d = 8'd0;
				dig_cnt_d = 2'd0;
				space_d   = 1'b0;
			end else begin
				if (word) begin
					// close any escape still open at the word end
					case (mode_d)
						MODE_BSL:  emit(res, res_n, CH_BSL);
						MODE_OCT:  emit(res, res_n, esc_val_d);
						MODE_HEX0: begin
							emit(res, res_n, CH_BSL);
							emit(res, res_n, CH_LX);
						end
						MODE_HEX1: emit(res, res_n, esc_val_d);
						default: ;
					endcase
					mode_d    = MODE_IDLE;
					esc_val_d = 8'd0;
					dig_cnt_d = 2'd0;
					if (line) begin
						if (newline_enable)
							emit(res, res_n, CH_NL);
						space_d = 1'b0;
					end else begin
						space_d = 1'b1;
					end
				end
				if (line && res_n == '0) begin
					res_n   = RES_CNT_W'(1);
					no_byte = 1'b1;
				end
			end
		end
	end

	always_comb begin
		push.push          = accept && (res_n != '0);
		push.data.bytes    = res;
		push.data.last_idx = RES_IDX_W'(res_n - RES_CNT_W'(1));
		push.data.no_byte  = no_byte;
		push.data.done     = line || stop;
		push.data.stopped  = stop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			esc_val_q <= 8'd0;
			dig_cnt_q <= 2'd0;
			space_q   <= 1'b0;
		end else if (accept) begin
			mode_q    <= mode_d;
			esc_val_q <= esc_val_d;
			dig_cnt_q <= dig_cnt_d;
			space_q   <= space_d;
		end
	end

endmodule

@@ rtl/bsed_queue.sv @@
// short queue of result bundles between front and back
module bsed_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bsed_pkg::push_t push,
	output logic            ready,
	output bsed_pkg::head_t head,
	input  logic            pop
);
	import bsed_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	bundle_t            entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_pop;

	assign ready      = count_q != CNT_W'(DEPTH);
	assign head.valid = count_q != '0;
	assign head.data  = entry_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push.push)
			entry_q[wr_ptr_q] <= push.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push.push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (!push.push && do_pop)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

@@ rtl/bsed_back.sv @@
// back: sends bundle results one per cycle unless the output stalls, via an output register
module bsed_back (
	input  logic            clk,
	input  logic            arst_n,
	input  bsed_pkg::head_t head,
	output logic            pop,
	bsed_out_if.source      out_item
);
	import bsed_pkg::*;

	logic [RES_IDX_W-1:0] idx_q;
	logic                 load;
	logic                 is_last;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 byte_valid_q, run_last_q, done_q, stopped_q;

	assign load    = !out_valid_q || out_item.ready;
	assign is_last = idx_q == head.data.last_idx;
	assign pop     = load && head.valid && is_last;

	assign out_item.valid       = out_valid_q;
	assign out_item.out_byte    = out_byte_q;
	assign out_item.byte_valid  = byte_valid_q;
	assign out_item.run_last    = run_last_q;
	assign out_item.output_done = done_q;
	assign out_item.stopped     = stopped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= head.valid;
			if (head.valid)
				idx_q <= is_last ? '0 : idx_q + RES_IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= head.data.no_byte ? 8'd0 : head.data.bytes[idx_q];
			byte_valid_q <= !head.data.no_byte;
			run_last_q   <= is_last;
			done_q       <= is_last && head.data.done;
			stopped_q    <= is_last && head.data.stopped;
		end
	end

endmodule

@@ verif/tb_backslash_escape_decoder.sv @@
// self-checking testbench of the backslash escape decoder: directed table, then random echo lines
`timescale 1ns / 1ps

module tb_backslash_escape_decoder;
	import bsed_pkg::*;

	// clock, limits and pacing
	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 9;
	localparam int SETTLE_CYCLES = 8;     // covers a transaction that makes no result
	localparam int TAIL_CYCLES   = 20;
	localparam int WDOG_LIMIT    = 2000;  // cycles without any transaction
	localparam int HOLD_CYCLES   = 64;    // long receiver hold-off, queue fills up
	localparam int N_PHASES      = 8;
	localparam int PHASE_ITEMS   = 32;
	localparam int MAX_REPORTS   = 10;

	// register byte addresses
	localparam logic [2:0] REG_ESCAPE_ENABLE  = 3'd0;
	localparam logic [2:0] REG_NEWLINE_ENABLE = 3'd4;

	// text bytes the decoder treats specially
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_X     = "x";
	localparam logic [7:0] CH_STOP  = "c";
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ESC   = 8'h1B;

	// bytes worth placing right after a backslash
	localparam logic [7:0] ESC_FOLLOW [12] = '{CH_BSL, "a", "b", CH_STOP, "e", "f", "n", "r",
		"t", "v", "0", CH_X};

	// decoder state as the predictor keeps it
	typedef enum logic [2:0] {
		DM_IDLE, DM_BSL, DM_OCT, DM_HEX0, DM_HEX1, DM_DROP
	} dec_mode_e;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       byte_present;
		logic       word_end;
		logic       line_end;
	} echo_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       output_done;
		logic       stopped;
	} echo_res_t;

	// one row of the directed table: a register setting or an input transaction
	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

	typedef struct packed {
		row_kind_e  kind;
		logic       cfg_esc;
		logic       cfg_nl;
		echo_in_t   item;
		logic       typed;    // expected results typed in the row itself
		logic [1:0] n_typed;
		echo_res_t  r0;
		echo_res_t  r1;
	} dir_row_t;

	localparam echo_res_t NO_RES = '0;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	bsed_in_if  in_if();
	bsed_out_if out_if();

	backslash_escape_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_if),
		.out_item (out_if),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// predictor copy of registers and decoder state
	logic      dec_esc_en;
	logic      dec_nl_en;
	dec_mode_e dec_mode;
	logic [7:0] dec_value;
	logic [1:0] dec_digits;
	logic      dec_space;

	echo_res_t item_out_q[$];     // results of the transaction being predicted
	echo_res_t decoded_q[$];      // results still owed by the block, oldest first
	echo_in_t  line_q[$];         // generated echo line waiting to be sent

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	logic hold_req     = 1'b0;

	int mismatches   = 0;
	int items_sent   = 0;
	int results_seen = 0;
	int lines_closed = 0;
	int stops_seen   = 0;
	int quiet_cycles = 0;

	function automatic echo_res_t res_of(logic [7:0] b, logic bv, logic rl, logic od,
		logic st);
		echo_res_t r;
		r.out_byte    = b;
		r.byte_valid  = bv;
		r.run_last    = rl;
		r.output_done = od;
		r.stopped     = st;
		return r;
	endfunction

	function automatic dir_row_t dir_chk(logic [7:0] b, logic pr, logic we, logic le,
		logic [1:0] n, echo_res_t r0, echo_res_t r1);
		dir_row_t r;
		r.kind    = ROW_ITEM;
		r.cfg_esc = 1'b0;
		r.cfg_nl  = 1'b0;
		r.item    = '{b, pr, we, le};
		r.typed   = 1'b1;
		r.n_typed = n;
		r.r0      = r0;
		r.r1      = r1;
		return r;
	endfunction

	function automatic dir_row_t dir_txt(logic [7:0] b, logic pr, logic we, logic le);
		dir_row_t r;
		r = dir_chk(b, pr, we, le, 2'd0, NO_RES, NO_RES);
		r.typed = 1'b0;
		return r;
	endfunction

	function automatic dir_row_t dir_cfg(logic esc, logic nl);
		dir_row_t r;
		r = dir_txt(8'h00, 1'b0, 1'b0, 1'b0);
		r.kind    = ROW_CFG;
		r.cfg_esc = esc;
		r.cfg_nl  = nl;
		return r;
	endfunction

	// directed table; rows without typed results go through the predictor
	localparam int DIR_ROWS = 27;
	dir_row_t dir_tab [DIR_ROWS] = '{
		// right after reset: escapes off, newline on
		dir_chk("A", 1'b1, 1'b0, 1'b0, 2'd1, res_of("A", 1'b1, 1'b1, 1'b0, 1'b0), NO_RES),
		dir_chk(8'h00, 1'b1, 1'b1, 1'b1, 2'd2, res_of(8'h00, 1'b1, 1'b0, 1'b0, 1'b0),
			res_of(CH_NL, 1'b1, 1'b1, 1'b1, 1'b0)),
		dir_chk(8'hFF, 1'b1, 1'b1, 1'b0, 2'd1, res_of(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0), NO_RES),
		// backslash copied as is, after the joining space
		dir_chk(CH_BSL, 1'b1, 1'b0, 1'b0, 2'd2, res_of(CH_SPACE, 1'b1, 1'b0, 1'b0, 1'b0),
			res_of(CH_BSL, 1'b1, 1'b1, 1'b0, 1'b0)),
		// no byte and no mark: nothing happens
		dir_chk(8'h00, 1'b0, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES),
		// empty line end still closes with a newline
		dir_chk(8'h00, 1'b0, 1'b1, 1'b1, 2'd1, res_of(CH_NL, 1'b1, 1'b1, 1'b1, 1'b0), NO_RES),
		dir_cfg(1'b0, 1'b0),
		// line end alone with nothing to send: one result without a byte
		dir_chk(8'h00, 1'b0, 1'b0, 1'b1, 2'd1, res_of(8'h00, 1'b0, 1'b1, 1'b1, 1'b0), NO_RES),
		dir_cfg(1'b1, 1'b1),
		dir_txt(CH_BSL, 1'b1, 1'b0, 1'b0), dir_txt(CH_BSL, 1'b1, 1'b0, 1'b0),
		// octal with three digits, top value
		dir_txt(CH_BSL, 1'b1, 1'b0, 1'b0), dir_txt("0", 1'b1, 1'b0, 1'b0),
		dir_txt("3", 1'b1, 1'b0, 1'b0), dir_txt("7", 1'b1, 1'b0, 1'b0),
		dir_txt("7", 1'b1, 1'b0, 1'b0),
		// hex with both digit cases, ended by word end
		dir_txt(CH_BSL, 1'b1, 1'b0, 1'b0), dir_txt(CH_X, 1'b1, 1'b0, 1'b0),
		dir_txt("f", 1'b1, 1'b0, 1'b0), dir_txt("F", 1'b1, 1'b1, 1'b0),
		// unknown escape, then lone backslash at word end
		dir_txt(CH_BSL, 1'b1, 1'b0, 1'b0), dir_txt("q", 1'b1, 1'b0, 1'b0),
		dir_txt(CH_BSL, 1'b1, 1'b1, 1'b0),
		// stop escape, dropped byte, line end during drop
		dir_txt(CH_BSL, 1'b1, 1'b0, 1'b0),
		dir_chk(CH_STOP, 1'b1, 1'b0, 1'b0, 2'd1, res_of(8'h00, 1'b0, 1'b1, 1'b1, 1'b1), NO_RES),
		dir_chk("z", 1'b1, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES),
		dir_chk(8'h00, 1'b0, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES)
	};

	function automatic void put_byte(logic [7:0] b);
		if (item_out_q.size() < RES_MAX)
			item_out_q.push_back(res_of(b, 1'b1, 1'b0, 1'b0, 1'b0));
	endfunction

	function automatic int hex_val(logic [7:0] c);
		if (c >= "0" && c <= "9")
			return int'(c - "0");
		if (c >= "a" && c <= "f")
			return int'(c - "a") + 10;
		if (c >= "A" && c <= "F")
			return int'(c - "A") + 10;
		return -1;
	endfunction

	// one text byte through the escape machine; 1 when the stop escape is met
	function automatic logic feed_byte(logic [7:0] b);
		int h;
		case (dec_mode)
			DM_BSL: begin
				dec_mode = DM_IDLE;
				case (b)
					CH_BSL:  put_byte(CH_BSL);
					"a":     put_byte(8'h07);
					"b":     put_byte(8'h08);
					CH_STOP: return 1'b1;
					"e":     put_byte(CH_ESC);
					"f":     put_byte(8'h0C);
					"n":     put_byte(CH_NL);
					"r":     put_byte(8'h0D);
					"t":     put_byte(8'h09);
					"v":     put_byte(8'h0B);
					"0": begin
						dec_mode   = DM_OCT;
						dec_value  = 8'h00;
						dec_digits = 2'd0;
					end
					CH_X:    dec_mode = DM_HEX0;
					default: begin
						put_byte(CH_BSL);
						put_byte(b);
					end
				endcase
				return 1'b0;
			end
			DM_OCT: begin
				if (b >= "0" && b <= "7") begin
					dec_value  = {dec_value[4:0], b[2:0]};
					dec_digits = dec_digits + 2'd1;
					if (dec_digits == 2'd3) begin
						put_byte(dec_value);
						dec_mode   = DM_IDLE;
						dec_digits = 2'd0;
					end
					return 1'b0;
				end
				put_byte(dec_value);
				dec_mode   = DM_IDLE;
				dec_digits = 2'd0;
			end
			DM_HEX0: begin
				h = hex_val(b);
				if (h >= 0) begin
					dec_value = 8'(h);
					dec_mode  = DM_HEX1;
					return 1'b0;
				end
				put_byte(CH_BSL);
				put_byte(CH_X);
				dec_mode = DM_IDLE;
			end
			DM_HEX1: begin
				h = hex_val(b);
				dec_mode = DM_IDLE;
				if (h >= 0) begin
					put_byte({dec_value[3:0], 4'(h)});
					return 1'b0;
				end
				put_byte(dec_value);
			end
			default: dec_mode = DM_IDLE;
		endcase
		// byte after a finished or broken escape is plain text
		if (dec_esc_en && b == CH_BSL)
			dec_mode = DM_BSL;
		else
			put_byte(b);
		return 1'b0;
	endfunction

	// results that one accepted input transaction should cause, into item_out_q
	function automatic void decode_echo_item(echo_in_t t);
		logic line, word, stop;
		line = t.line_end;
		word = t.line_end | t.word_end;
		item_out_q.delete();
		if (dec_mode == DM_DROP) begin
			if (line) begin
				dec_mode  = DM_IDLE;
				dec_space = 1'b0;
			end
			return;
		end
		if (dec_mode > DM_HEX1)
			dec_mode = DM_IDLE;
		if (!t.byte_present && !word)
			return;
		if (dec_space) begin
			put_byte(CH_SPACE);
			dec_space = 1'b0;
		end
		stop = t.byte_present ? feed_byte(t.text_byte) : 1'b0;
		if (stop) begin
			// stop escape discards everything else of this transaction
			item_out_q.delete();
			item_out_q.push_back(res_of(8'h00, 1'b0, 1'b1, 1'b1, 1'b1));
			dec_mode   = line ? DM_IDLE : DM_DROP;
			dec_value  = 8'h00;
			dec_digits = 2'd0;
			dec_space  = 1'b0;
			return;
		end
		if (word) begin
			// pending escape is sent as far as it got
			case (dec_mode)
				DM_BSL:  put_byte(CH_BSL);
				DM_OCT:  put_byte(dec_value);
				DM_HEX0: begin
					put_byte(CH_BSL);
					put_byte(CH_X);
				end
				DM_HEX1: put_byte(dec_value);
				default: ;
			endcase
			dec_mode   = DM_IDLE;
			dec_value  = 8'h00;
			dec_digits = 2'd0;
			if (line) begin
				if (dec_nl_en)
					put_byte(CH_NL);
				dec_space = 1'b0;
			end else begin
				dec_space = 1'b1;
			end
		end
		if (line && item_out_q.size() == 0)
			item_out_q.push_back(res_of(8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
		if (item_out_q.size() == 0)
			return;
		item_out_q[item_out_q.size() - 1].run_last = 1'b1;
		if (line)
			item_out_q[item_out_q.size() - 1].output_done = 1'b1;
	endfunction

	// counts a failure; 1 while it should still be printed
	function automatic logic note_fault();
		mismatches++;
		return mismatches <= MAX_REPORTS;
	endfunction

	// biased toward backslashes, escape letters and digits
	function automatic logic [7:0] pick_text_byte();
		case ($urandom_range(9))
			0, 1: return CH_BSL;
			2, 3: return ESC_FOLLOW[$urandom_range(11)];
			4: return 8'($urandom_range(8'h39, 8'h30));
			5: return $urandom_range(1) ? 8'($urandom_range(8'h66, 8'h61)) :
				8'($urandom_range(8'h46, 8'h41));
			6: return CH_STOP;
			default: return 8'($urandom);
		endcase
	endfunction

	// one well-formed echo line with random content, sprinkled with noise;
	// returns how many transactions it queued, not counting the no-byte, no-mark ones
	function automatic int make_line();
		int n_words, n_bytes, n_slots, w, k, counted;
		echo_in_t t;
		counted = 0;
		n_words = $urandom_range(4, 1);
		for (w = 0; w < n_words; w++) begin
			n_bytes = ($urandom_range(7) == 0) ? 0 : $urandom_range(6, 1);
			n_slots = (n_bytes == 0) ? 1 : n_bytes;
			for (k = 0; k < n_slots; k++) begin
				if ($urandom_range(99) < 8) begin
					// no byte, no mark
					t = '{8'($urandom), 1'b0, 1'b0, 1'b0};
					line_q.push_back(t);
				end else if ($urandom_range(99) < 4) begin
					// broken sequence: random marks anywhere
					t = echo_in_t'(11'($urandom));
					line_q.push_back(t);
					counted++;
				end
				t.text_byte    = (n_bytes == 0) ? 8'($urandom) : pick_text_byte();
				t.byte_present = (n_bytes != 0);
				t.word_end     = (k == n_slots - 1);
				t.line_end     = (k == n_slots - 1) && (w == n_words - 1);
				// line end alone implies word end
				if (t.line_end && $urandom_range(1))
					t.word_end = 1'b0;
				line_q.push_back(t);
				counted++;
			end
		end
		return counted;
	endfunction

	// offer one transaction, predict it once accepted
	task automatic send_row(input dir_row_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid        <= 1'b1;
		in_if.text_byte    <= r.item.text_byte;
		in_if.byte_present <= r.item.byte_present;
		in_if.word_end     <= r.item.word_end;
		in_if.line_end     <= r.item.line_end;
		@(posedge clk);
		while (!in_if.ready)
			@(posedge clk);
		decode_echo_item(r.item);
		if (r.typed) begin
			if (r.n_typed > 0)
				decoded_q.push_back(r.r0);
			if (r.n_typed > 1)
				decoded_q.push_back(r.r1);
		end else begin
			foreach (item_out_q[i])
				decoded_q.push_back(item_out_q[i]);
		end
		items_sent++;
	endtask

	// stop offering and let every owed result come out
	task automatic wait_drained();
		in_if.valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both registers, then read both back; the block must be idle
	task automatic set_config(input logic esc, input logic nl);
		int k;
		logic val;
		for (k = 0; k < 4; k++) begin
			val = (k % 2 != 0) ? nl : esc;
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= (k < 2);
			paddr   <= (k % 2 != 0) ? REG_NEWLINE_ENABLE : REG_ESCAPE_ENABLE;
			pwdata  <= {31'b0, val};
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready)
				@(posedge clk);
			if (k == 0)
				dec_esc_en = esc;
			else if (k == 1)
				dec_nl_en = nl;
			else if (prdata !== {31'b0, val} && note_fault())
				$display("register read at %0d: expected %0d, got %h",
					(k % 2 != 0) ? REG_NEWLINE_ENABLE : REG_ESCAPE_ENABLE, val, prdata);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// receiver: random stalls, or one long hold-off when asked
	initial begin
		out_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// result checker: each output transaction against the oldest expectation
	always @(posedge clk) begin : result_check
		echo_res_t got, want;
		if (arst_n && out_if.valid && out_if.ready) begin
			got = res_of(out_if.out_byte, out_if.byte_valid, out_if.run_last,
				out_if.output_done, out_if.stopped);
			results_seen++;
			if (got.output_done)
				lines_closed++;
			if (got.stopped)
				stops_seen++;
			if (decoded_q.size() == 0) begin
				if (note_fault())
					$display("unexpected result: byte %h valid %b last %b done %b stop %b",
						got.out_byte, got.byte_valid, got.run_last, got.output_done,
						got.stopped);
			end else begin
				want = decoded_q.pop_front();
				if (got !== want && note_fault())
					$display("result %0d: expected byte %h valid %b last %b done %b stop %b, %s",
						results_seen, want.out_byte, want.byte_valid, want.run_last,
						want.output_done, want.stopped,
						$sformatf("got byte %h valid %b last %b done %b stop %b",
						got.out_byte, got.byte_valid, got.run_last, got.output_done,
						got.stopped));
			end
		end
	end

	// watchdog: ends a run that stops moving
	always @(posedge clk) begin
		if (!arst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d results owed",
				quiet_cycles, decoded_q.size());
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int ph, phase_count;
		logic held;
		logic paused;

		// every input known from time zero
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		in_if.valid        = 1'b0;
		in_if.text_byte    = '0;
		in_if.byte_present = 1'b0;
		in_if.word_end     = 1'b0;
		in_if.line_end     = 1'b0;

		// predictor starts from the reset state
		dec_esc_en = 1'b0;
		dec_nl_en  = 1'b1;
		dec_mode   = DM_IDLE;
		dec_value  = 8'h00;
		dec_digits = 2'd0;
		dec_space  = 1'b0;
		held       = 1'b0;
		paused     = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling on either side
		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				wait_drained();
				set_config(dir_tab[i].cfg_esc, dir_tab[i].cfg_nl);
			end else begin
				send_row(dir_tab[i]);
			end
		end

		// random phases: idling pattern cycles through four modes, registers vary
		for (ph = 0; ph < N_PHASES; ph++) begin
			wait_drained();
			set_config(ph % 3 != 2, (ph >> 1) % 2 != 0);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
				default: begin send_idle_pct = 25; recv_stall_pct = 25; end
			endcase
			phase_count = 0;
			while (phase_count < PHASE_ITEMS) begin
				phase_count += make_line();
				while (line_q.size() != 0) begin
					send_row(dir_txt(line_q[0].text_byte, line_q[0].byte_present,
						line_q[0].word_end, line_q[0].line_end));
					void'(line_q.pop_front());
				end
				// long receiver hold-off while input keeps coming
				if (ph == 0 && !held && phase_count >= 12) begin
					hold_req = 1'b1;
					held     = 1'b1;
				end
				// sender pauses until every owed result is out
				if (ph == 5 && !paused && phase_count >= 20) begin
					wait_drained();
					paused = 1'b1;
				end
			end
			// leave an escape open across the register change, when escapes are on
			send_row(dir_txt(CH_BSL, 1'b1, 1'b0, 1'b0));
		end

		// close the open word and line, then drain
		send_row(dir_txt(8'h00, 1'b0, 1'b1, 1'b1));
		in_if.valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run: %0d input transactions over %0d phases, %0d results checked",
			items_sent, N_PHASES, results_seen);
		$display("run: %0d lines closed, %0d stop escapes, %0d failures",
			lines_closed, stops_seen, mismatches);
		if (mismatches == 0 && decoded_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ backslash_escape_decoder.f @@
rtl/bsed_pkg.sv
rtl/bsed_in_if.sv
rtl/bsed_out_if.sv
rtl/bsed_front.sv
rtl/bsed_queue.sv
rtl/bsed_back.sv
rtl/backslash_escape_decoder.sv
verif/tb_backslash_escape_decoder.sv
